FILE: design/heron_pkg.sv
// Shared constants for the fixed-point Heron triangle area core.
package heron_pkg;

   // Default coordinate width and fractional bits of the vertex inputs.
   localparam int COORD_WIDTH_DEF = 20;
   localparam int FRAC_BITS_DEF   = 8;

   // Width of the area result, which saturates at its all-ones value.
   localparam int AREA_W = 33;

endpackage

FILE: design/heron_isqrt.sv
// Pipelined floor integer square root, one result bit resolved per stage.
module heron_isqrt #(
   parameter int IN_W = 42
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_vld,
   input  logic [IN_W-1:0]      in_rad,
   output logic                 out_vld,
   output logic [IN_W/2-1:0]    out_root
);
   import heron_pkg::*;

   localparam int N    = IN_W / 2;
   localparam int RM_W = N + 2;

   logic [IN_W-1:0] rad_ff  [N];
   logic [RM_W-1:0] rem_ff  [N];
   logic [N-1:0]    root_ff [N];
   logic [N-1:0]    vld_ff;

   // Each stage brings down two radicand bits and tries the next root bit.
   for (genvar g = 0; g < N; g++) begin : g_stage
      logic [IN_W-1:0] rad_prev;
      logic [RM_W-1:0] rem_prev;
      logic [N-1:0]    root_prev;
      logic            vld_prev;
      logic [RM_W+1:0] trial_w;
      logic [RM_W+1:0] sub_w;
      logic [RM_W+1:0] diff_w;
      logic            fits;

      if (g == 0) begin : g_first
         assign rad_prev  = in_rad;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign vld_prev  = in_vld;
      end else begin : g_next
         assign rad_prev  = rad_ff[g-1];
         assign rem_prev  = rem_ff[g-1];
         assign root_prev = root_ff[g-1];
         assign vld_prev  = vld_ff[g-1];
      end

      // Trial subtraction of 4*root+1 from the shifted-in partial remainder.
      always_comb begin
         trial_w = {rem_prev, rad_prev[IN_W-1 -: 2]};
         sub_w   = {2'b00, root_prev, 2'b01};
         diff_w  = trial_w - sub_w;
         fits    = (trial_w >= sub_w);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else begin
            vld_ff[g] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[g]  <= rad_prev << 2;
         rem_ff[g]  <= fits ? diff_w[RM_W-1:0] : trial_w[RM_W-1:0];
         root_ff[g] <= {root_prev[N-2:0], fits};
      end
   end

   assign out_vld  = vld_ff[N-1];
   assign out_root = root_ff[N-1];

endmodule

FILE: design/triangle_area_heron_core.sv
// Top level of the pipelined fixed-point Heron triangle area core.
//
// One triangle, three signed 3-D vertices, is taken per transaction when
// start is high; busy is always low, so a transaction may be started in
// every clock cycle and many triangles are in flight at once.
// Each result appears on rsp_area for exactly one cycle with rsp_valid high,
// in the order the transactions were started.
// The stages, in order, form squared edge differences, take the edge
// square roots (one root bit per stage), form the Heron product with
// partial products, take the area square root, and scale and saturate.
// The core takes one triangle per cycle.
// Synchronous reset clears every valid bit, dropping triangles in flight;
// data registers are not reset.
// The receiver cannot stall, so no result is ever held back.
module triangle_area_heron_core #(
   parameter int COORD_WIDTH = heron_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = heron_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [COORD_WIDTH-1:0]        req_v1_x,
   input  logic signed [COORD_WIDTH-1:0]        req_v1_y,
   input  logic signed [COORD_WIDTH-1:0]        req_v1_z,
   input  logic signed [COORD_WIDTH-1:0]        req_v2_x,
   input  logic signed [COORD_WIDTH-1:0]        req_v2_y,
   input  logic signed [COORD_WIDTH-1:0]        req_v2_z,
   input  logic signed [COORD_WIDTH-1:0]        req_v3_x,
   input  logic signed [COORD_WIDTH-1:0]        req_v3_y,
   input  logic signed [COORD_WIDTH-1:0]        req_v3_z,
   output logic                                 rsp_valid,
   output logic [heron_pkg::AREA_W-1:0]         rsp_area
);
   import heron_pkg::*;

   // The perimeter can reach about 4.25 times the coordinate span, so the
   // signed factors carry three bits above the edge length.
   localparam int CW    = COORD_WIDTH;
   localparam int SUM_W = 2 * CW + 2;
   localparam int E_W   = SUM_W / 2;
   localparam int F_W   = E_W + 3;
   localparam int PW    = 2 * F_W;
   localparam int H     = PW / 2;
   localparam int HP_W  = 2 * PW;
   localparam int SHIFT = FRAC_BITS + 2;
   localparam int CMP_W = (PW > AREA_W) ? PW : AREA_W;
   localparam logic [CMP_W-1:0] AMAX = CMP_W'({AREA_W{1'b1}});

   // Magnitude of a coordinate difference; it always fits in CW bits.
   function automatic logic [CW-1:0] abs_diff(input logic signed [CW-1:0] p,
                                              input logic signed [CW-1:0] q);
      logic signed [CW:0] d;
      logic signed [CW:0] n;
      d = $signed({p[CW-1], p}) - $signed({q[CW-1], q});
      n = -d;
      return d[CW] ? n[CW-1:0] : d[CW-1:0];
   endfunction

   // Magnitude of a signed factor of the Heron product.
   function automatic logic [F_W-1:0] abs_f(input logic signed [F_W-1:0] s);
      logic signed [F_W-1:0] n;
      n = -s;
      return s[F_W-1] ? n : s;
   endfunction

   assign busy = 1'b0;

   // Input stage: absolute coordinate differences for the edges ab, ac and cb.
   logic          dif_vld_ff;
   logic [CW-1:0] dab_ff [3];
   logic [CW-1:0] dac_ff [3];
   logic [CW-1:0] dcb_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         dif_vld_ff <= 1'b0;
      end else begin
         dif_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      dab_ff[0] <= abs_diff(req_v1_x, req_v2_x);
      dab_ff[1] <= abs_diff(req_v1_y, req_v2_y);
      dab_ff[2] <= abs_diff(req_v1_z, req_v2_z);
      dac_ff[0] <= abs_diff(req_v1_x, req_v3_x);
      dac_ff[1] <= abs_diff(req_v1_y, req_v3_y);
      dac_ff[2] <= abs_diff(req_v1_z, req_v3_z);
      dcb_ff[0] <= abs_diff(req_v3_x, req_v2_x);
      dcb_ff[1] <= abs_diff(req_v3_y, req_v2_y);
      dcb_ff[2] <= abs_diff(req_v3_z, req_v2_z);
   end

   // Stage 2: squared edge lengths.
   logic             sq_vld_ff;
   logic [SUM_W-1:0] sq_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= 1'b0;
      end else begin
         sq_vld_ff <= dif_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff[0] <= SUM_W'(dab_ff[0]) * SUM_W'(dab_ff[0])
                + SUM_W'(dab_ff[1]) * SUM_W'(dab_ff[1])
                + SUM_W'(dab_ff[2]) * SUM_W'(dab_ff[2]);
      sq_ff[1] <= SUM_W'(dac_ff[0]) * SUM_W'(dac_ff[0])
                + SUM_W'(dac_ff[1]) * SUM_W'(dac_ff[1])
                + SUM_W'(dac_ff[2]) * SUM_W'(dac_ff[2]);
      sq_ff[2] <= SUM_W'(dcb_ff[0]) * SUM_W'(dcb_ff[0])
                + SUM_W'(dcb_ff[1]) * SUM_W'(dcb_ff[1])
                + SUM_W'(dcb_ff[2]) * SUM_W'(dcb_ff[2]);
   end

   // Edge lengths a, b and c through three square-root pipelines.
   logic [2:0]     edge_vld;
   logic [E_W-1:0] edge_len [3];

   for (genvar e = 0; e < 3; e++) begin : g_edge
      heron_isqrt #(
         .IN_W (SUM_W)
      ) u_edge_sqrt (
         .clock    (clock),
         .reset    (reset),
         .in_vld   (sq_vld_ff),
         .in_rad   (sq_ff[e]),
         .out_vld  (edge_vld[e]),
         .out_root (edge_len[e])
      );
   end

   // Stage 3: the four Heron factors as magnitudes.
   logic                  fac_vld_ff;
   logic [F_W-1:0]        f1_ff, f2_ff, f3_ff, f4_ff;
   logic signed [F_W-1:0] ea, eb, ec;

   always_comb begin
      ea = $signed(F_W'(edge_len[0]));
      eb = $signed(F_W'(edge_len[1]));
      ec = $signed(F_W'(edge_len[2]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fac_vld_ff <= 1'b0;
      end else begin
         fac_vld_ff <= edge_vld[0];
      end
   end

   always_ff @(posedge clock) begin
      f1_ff <= abs_f(ea + eb + ec);
      f2_ff <= abs_f(eb + ec - ea);
      f3_ff <= abs_f(ec + ea - eb);
      f4_ff <= abs_f(ea + eb - ec);
   end

   // Stage 4: two pairwise products of the factors.
   logic          pair_vld_ff;
   logic [PW-1:0] p12_ff, p34_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_vld_ff <= 1'b0;
      end else begin
         pair_vld_ff <= fac_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p12_ff <= PW'(f1_ff) * PW'(f2_ff);
      p34_ff <= PW'(f3_ff) * PW'(f4_ff);
   end

   // Stage 5: half-width partial products of the wide final multiply.
   logic          part_vld_ff;
   logic [PW-1:0] pll_ff, plh_ff, phl_ff, phh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         part_vld_ff <= 1'b0;
      end else begin
         part_vld_ff <= pair_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      pll_ff <= PW'(p12_ff[H-1:0])  * PW'(p34_ff[H-1:0]);
      plh_ff <= PW'(p12_ff[H-1:0])  * PW'(p34_ff[PW-1:H]);
      phl_ff <= PW'(p12_ff[PW-1:H]) * PW'(p34_ff[H-1:0]);
      phh_ff <= PW'(p12_ff[PW-1:H]) * PW'(p34_ff[PW-1:H]);
   end

   // Stage 6: recombine the partial products into the Heron product.
   logic            hp_vld_ff;
   logic [HP_W-1:0] hp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hp_vld_ff <= 1'b0;
      end else begin
         hp_vld_ff <= part_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      hp_ff <= (HP_W'(phh_ff) << (2 * H))
             + ((HP_W'(plh_ff) + HP_W'(phl_ff)) << H)
             + HP_W'(pll_ff);
   end

   // Square root of the Heron product.
   logic          root_vld;
   logic [PW-1:0] root;

   heron_isqrt #(
      .IN_W (HP_W)
   ) u_area_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (hp_vld_ff),
      .in_rad   (hp_ff),
      .out_vld  (root_vld),
      .out_root (root)
   );

   // Final stage: divide by four, drop fraction bits, saturate.
   logic              out_vld_ff;
   logic [AREA_W-1:0] area_ff;
   logic [CMP_W-1:0]  scaled;

   assign scaled = CMP_W'(root >> SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= root_vld;
      end
   end

   always_ff @(posedge clock) begin
      area_ff <= (scaled > AMAX) ? {AREA_W{1'b1}} : scaled[AREA_W-1:0];
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_area  = area_ff;

   // The a, b and c edge pipelines always raise their valid outputs together.
   a_edge_lockstep : assert property (@(posedge clock) disable iff (reset)
      (edge_vld[0] == edge_vld[1]) && (edge_vld[1] == edge_vld[2]))
      else $error("edge square-root pipelines out of step");

   // The perimeter factor bounds every other factor.
   a_factor_bound : assert property (@(posedge clock) disable iff (reset)
      pair_vld_ff |-> ($past(f1_ff) >= $past(f2_ff)) && ($past(f1_ff) >= $past(f3_ff))
                      && ($past(f1_ff) >= $past(f4_ff)))
      else $error("Heron factor exceeds the perimeter");

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the pipelined Heron triangle area core.
module tb;
   import heron_pkg::*;

   localparam int CW = COORD_WIDTH_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int LATENCY = 3 * CW + 16;
   localparam int STALL_LIMIT = 20 * (LATENCY + 20);

   typedef logic signed [CW-1:0] coord_type;
   typedef struct packed {
      coord_type x1, y1, z1, x2, y2, z2, x3, y3, z3;
   } tri_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   coord_type v1_x = '0, v1_y = '0, v1_z = '0;
   coord_type v2_x = '0, v2_y = '0, v2_z = '0;
   coord_type v3_x = '0, v3_y = '0, v3_z = '0;
   logic rsp_valid;
   logic [AREA_W-1:0] rsp_area;

   tri_type pending_tris[$];
   logic [AREA_W-1:0] expected_areas[$];
   int errors = 0;
   int idle_cycles = 0;
   int gap_left = 0;
   bit quiet_phase = 0;
   bit stim_done = 0;
   tri_type cur;

   triangle_area_heron_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_v1_x(v1_x), .req_v1_y(v1_y), .req_v1_z(v1_z),
      .req_v2_x(v2_x), .req_v2_y(v2_y), .req_v2_z(v2_z),
      .req_v3_x(v3_x), .req_v3_y(v3_y), .req_v3_z(v3_z),
      .rsp_valid(rsp_valid), .rsp_area(rsp_area)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Floor square root of a 128-bit value, one root bit at a time.
   function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= n) r = c;
      end
      return r;
   endfunction

   function automatic logic [63:0] edge_len(input coord_type ax, ay, az, bx, by, bz);
      longint dx, dy, dz;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      dz = longint'(az) - longint'(bz);
      return floor_sqrt(128'(dx * dx + dy * dy + dz * dz));
   endfunction

   function automatic logic [AREA_W-1:0] heron_area(input tri_type t);
      longint a, b, c, f1, f2, f3, f4;
      logic [127:0] prod;
      logic [63:0] root;
      logic [63:0] scaled;
      a = longint'(edge_len(t.x1, t.y1, t.z1, t.x2, t.y2, t.z2));
      b = longint'(edge_len(t.x1, t.y1, t.z1, t.x3, t.y3, t.z3));
      c = longint'(edge_len(t.x3, t.y3, t.z3, t.x2, t.y2, t.z2));
      f1 = a + b + c;  f1 = f1 < 0 ? -f1 : f1;
      f2 = b + c - a;  f2 = f2 < 0 ? -f2 : f2;
      f3 = c + a - b;  f3 = f3 < 0 ? -f3 : f3;
      f4 = a + b - c;  f4 = f4 < 0 ? -f4 : f4;
      prod = 128'(64'(f1 * f2)) * 128'(64'(f3 * f4));
      root = floor_sqrt(prod);
      scaled = root >> (FB + 2);
      if (scaled > {{(64-AREA_W){1'b0}}, {AREA_W{1'b1}}}) scaled = {AREA_W{1'b1}};
      return scaled[AREA_W-1:0];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   function automatic coord_type rand_coord(input int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'($urandom_range(0, 2047)) - coord_type'(1024);
         2: return ($urandom_range(0, 1)) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
         default: return coord_type'($urandom_range(0, 65535)) - coord_type'(32768);
      endcase
   endfunction

   // Driver: presents queued triangles at the falling edge, with random gaps outside the quiet phase.
   always @(negedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            // Last transaction was accepted at the preceding rising edge.
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_tris.size() > 0
                      && (quiet_phase || $urandom_range(0, 9) != 0)) begin
            cur = pending_tris.pop_front();
            v1_x <= cur.x1; v1_y <= cur.y1; v1_z <= cur.z1;
            v2_x <= cur.x2; v2_y <= cur.y2; v2_z <= cur.z2;
            v3_x <= cur.x3; v3_y <= cur.y3; v3_z <= cur.z3;
            expected_areas.push_back(heron_area(cur));
            start <= 1'b1;
         end else begin
            start <= 1'b0;
            if (!quiet_phase && pending_tris.size() > 0) gap_left = $urandom_range(1, 18) - 1;
         end
      end
   end

   // Monitor and watchdog: results are sampled at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            idle_cycles <= 0;
            if (expected_areas.size() == 0)
               report_mismatch($sformatf("unexpected area %0d", rsp_area));
            else if (rsp_area !== expected_areas[0]) begin
               report_mismatch($sformatf("area %0d, expected %0d",
                                         rsp_area, expected_areas[0]));
               void'(expected_areas.pop_front());
            end else
               void'(expected_areas.pop_front());
         end else if (start && !busy)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles > STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   task automatic add_tri(input coord_type a, b, c, d, e, f, g, h, i);
      tri_type t;
      t = '{a, b, c, d, e, f, g, h, i};
      pending_tris.push_back(t);
   endtask

   localparam coord_type CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam coord_type CMIN = {1'b1, {(CW-1){1'b0}}};

   initial begin
      tri_type t;
      int mode;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // Directed part: degenerate, extremes, obtuse and negative-factor cases.
      add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_tri(5, 5, 5, 5, 5, 5, 5, 5, 5);
      add_tri(0, 0, 0, 256, 0, 0, 512, 0, 0);
      add_tri(0, 0, 0, 256, 0, 0, 0, 256, 0);
      add_tri(0, 0, 0, 3, 0, 0, 0, 4, 0);
      add_tri(1, 2, 3, 2, 4, 6, 3, 6, 9);
      add_tri(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN);
      add_tri(CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX);
      add_tri(CMIN, CMIN, 0, CMAX, CMIN, 0, CMIN, CMAX, 0);
      add_tri(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX);
      add_tri(-1, -1, -1, 0, 0, 0, 1, 1, 1);
      add_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);
      add_tri(0, 0, 0, 1000, 0, 0, 500, 1, 0);
      add_tri(CMIN, 0, 0, CMAX, 0, 0, 0, CMAX, CMAX);
      add_tri(-7, 3, 0, 9, -2, 1, 0, 0, 5);
      add_tri(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
      // Random part: mixed magnitudes, some near-collinear triangles.
      for (int n = 0; n < 1650; n++) begin
         mode = $urandom_range(0, 3);
         t = '{rand_coord(mode), rand_coord(mode), rand_coord(mode),
               rand_coord(mode), rand_coord(mode), rand_coord(mode),
               rand_coord(mode), rand_coord(mode), rand_coord(mode)};
         if ($urandom_range(0, 7) == 0) begin
            t.x3 = t.x1 + (t.x2 - t.x1) / 2;
            t.y3 = t.y1 + (t.y2 - t.y1) / 2;
            t.z3 = t.z1 + (t.z2 - t.z1) / 2;
         end
         pending_tris.push_back(t);
      end
      while (pending_tris.size() > 200) @(posedge clock);
      quiet_phase = 1;
      while (pending_tris.size() > 0 || expected_areas.size() > 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end
endmodule
